// ===== design/tcb_pkg.sv =====
package tcb_pkg;

  localparam int MAX_COLS_DEF = 80;
  localparam int MAX_ROWS_DEF = 25;

  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CFG_W  = 7;

  localparam logic [COL_W-1:0]  COLS_RESET   = 7'd80;
  localparam logic [ROW_W-1:0]  ROWS_RESET   = 5'd25;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scroll_start;
    logic sweep;
    logic read_capture;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic scroll_needed;
    logic sweep_done;
    logic out_free;
  } ctl_stat_t;

endpackage

// ===== design/text_console_buffer.sv =====
// Text console cell buffer with a cursor.
// Input channel in_*: in_tuser is the opcode (put or read); in_tdata carries
// char_code, read_col and read_row. A put writes char_code at the cursor and
// advances it (newline moves to column 0 of the next row); on moving past the
// bottom row the whole screen scrolls up one row. A read returns one cell.
// Output channel out_*: one result item per input item with cell_value,
// cursor_col, cursor_row and scrolled.
// Items are handled one at a time: a put passes through accept, execute and
// load; a read adds a read-wait step between execute and load. A put that
// scrolls adds a scroll step between execute and load, one cell moved per cycle
// through the single-port-pair cell RAM, and leaves it once the last write is done.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle,
// which the block itself does not enforce; index 0 is the column count, index 1
// the row count. Reset clears the cursor and loads the default geometry, then
// sweeps zeros through the whole cell RAM before in_tready rises. The finished
// result sits in an output register: the next item is accepted while it waits,
// and that item holds in its last step until the receiver takes the previous
// result.
module text_console_buffer
  import tcb_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // char_code[7:0], read_col[14:8], read_row[19:15]
  input  logic             in_tuser,   // opcode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata   // cell_value[7:0], cursor_col[14:8],
                                       // cursor_row[19:15], scrolled[20]
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  tcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcb_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== design/tcb_ram.sv =====
module tcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tcb_ctrl.sv =====
module tcb_ctrl
  import tcb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SCROLL,
    S_DONE
  } state_t;

  state_t state;

  assign in_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR:   cmd.sweep = 1'b1;
      S_IDLE:    cmd.accept = in_tvalid;
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.scroll_start = !stat.is_read && stat.scroll_needed;
      end
      S_RD_WAIT: cmd.read_capture = 1'b1;
      S_SCROLL:  cmd.sweep = 1'b1;
      S_DONE:    cmd.out_load = stat.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.sweep_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (stat.is_read)           state <= S_RD_WAIT;
          else if (stat.scroll_needed) state <= S_SCROLL;
          else                         state <= S_DONE;
        end
        S_RD_WAIT: state <= S_DONE;
        S_SCROLL: begin
          if (stat.sweep_done) state <= S_DONE;
        end
        S_DONE: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

// ===== design/tcb_datapath.sv =====
module tcb_datapath
  import tcb_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  input  ctl_cmd_t    cmd,
  output ctl_stat_t   stat
);

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW    = $clog2(Depth + 1);

  logic [COL_W-1:0] cfg_cols;
  logic [ROW_W-1:0] cfg_rows;
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;

  logic              op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [COL_W-1:0]  rc_q;
  logic [ROW_W-1:0]  rr_q;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [CHAR_W-1:0] value;
  logic              scrolled;

  logic [SW-1:0] scnt;
  logic [SW-1:0] sweep_end;
  logic [SW-1:0] copy_lim;
  logic          wr_pend;
  logic          wr_zero;
  logic [AW-1:0] wr_addr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic [COL_W-1:0] col_sat;
  logic [ROW_W-1:0] row_sat;
  logic [COL_W:0]   col_inc;
  logic             is_nl;
  logic             wraps;
  logic             rd_ok;
  logic             issue;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    rd_addr;

  // Effective limits: zero acts as one, above the store size acts as the size
  always_comb begin
    if (cfg_cols == '0)                     w_eff = COL_W'(1);
    else if (32'(cfg_cols) > MAX_COLS)      w_eff = COL_W'(MAX_COLS);
    else                                    w_eff = cfg_cols;
    if (cfg_rows == '0)                     h_eff = ROW_W'(1);
    else if (32'(cfg_rows) > MAX_ROWS)      h_eff = ROW_W'(MAX_ROWS);
    else                                    h_eff = cfg_rows;
  end

  always_comb begin
    col_sat = (col >= w_eff) ? (w_eff - COL_W'(1)) : col;
    row_sat = (row >= h_eff) ? (h_eff - ROW_W'(1)) : row;
  end

  assign col_inc  = {1'b0, col} + (COL_W+1)'(1);
  assign is_nl    = (ch_q == NEWLINE_CODE);
  assign wraps    = is_nl || (col_inc >= {1'b0, w_eff});
  assign rd_ok    = (rc_q < w_eff) && (rr_q < h_eff);
  assign cur_addr = AW'(32'(row) * MAX_COLS + 32'(col));
  assign rd_addr  = rd_ok ? AW'(32'(rr_q) * MAX_COLS + 32'(rc_q)) : '0;
  assign issue    = cmd.sweep && (scnt < sweep_end);

  assign stat.is_read       = (op_q == OP_READ);
  assign stat.scroll_needed = wraps && ({1'b0, row} + (ROW_W+1)'(1) >= {1'b0, h_eff});
  assign stat.sweep_done    = (scnt >= sweep_end) && !wr_pend;
  assign stat.out_free      = !out_tvalid || out_tready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = ch_q;
    if (wr_pend) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr;
      ram_wdata = wr_zero ? '0 : ram_rdata;
    end else if (cmd.exec && op_q == OP_PUT && !is_nl) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    if (cmd.sweep) begin
      ram_raddr = (scnt < copy_lim) ? AW'(32'(scnt) + MAX_COLS) : '0;
    end else begin
      ram_raddr = rd_addr;
    end
  end

  tcb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols <= COLS_RESET;
      cfg_rows <= ROWS_RESET;
      col      <= '0;
      row      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_COLS) cfg_cols <= cfg_data;
        else                       cfg_rows <= ROW_W'(cfg_data);
      end
      if (cmd.accept) begin
        col <= col_sat;
        row <= row_sat;
      end else if (cmd.exec && op_q == OP_PUT) begin
        if (cmd.scroll_start) begin
          col <= '0;
          row <= h_eff - ROW_W'(1);
        end else if (wraps) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col_inc[COL_W-1:0];
        end
      end
    end
  end

  // Item fields and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= in_tuser;
      ch_q <= in_tdata[7:0];
      rc_q <= in_tdata[14:8];
      rr_q <= in_tdata[19:15];
    end
    if (cmd.exec) begin
      value    <= '0;
      scrolled <= cmd.scroll_start;
    end
    if (cmd.read_capture) begin
      value <= rd_ok ? ram_rdata : '0;
    end
    if (cmd.out_load) begin
      out_tdata <= {3'b000, scrolled, row, col, value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  // Sweep engine: shift rows up by one stride, zero the tail; reset uses it to clear
  always_ff @(posedge clk) begin
    if (rst) begin
      scnt      <= '0;
      sweep_end <= SW'(Depth);
      copy_lim  <= '0;
      wr_pend   <= 1'b0;
    end else begin
      if (cmd.scroll_start) begin
        scnt      <= '0;
        copy_lim  <= SW'(32'(h_eff - ROW_W'(1)) * MAX_COLS);
        sweep_end <= SW'(32'(h_eff) * MAX_COLS);
      end else if (issue) begin
        scnt <= scnt + SW'(1);
      end
      wr_pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      wr_addr <= scnt[AW-1:0];
      wr_zero <= !(scnt < copy_lim);
    end
  end

endmodule

// ===== sim/console_checker.sv =====
`timescale 1ns / 100ps
module console_checker
  import tcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [23:0]      in_tdata,   // char_code[7:0], read_col[14:8], read_row[19:15]
  input  logic             in_tuser,   // opcode
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [23:0]      out_tdata,  // cell_value[7:0], cursor_col[14:8],
                                       // cursor_row[19:15], scrolled[20]
  output int               fails,
  output int               pending
);

  localparam int STRIDE = MAX_COLS_DEF;
  localparam int CELLS  = MAX_COLS_DEF * MAX_ROWS_DEF;

  typedef struct packed {
    logic              scrolled;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_value;
  } console_result_t;

  logic [CHAR_W-1:0] screen [CELLS];
  logic [COL_W-1:0]  width_reg;
  logic [ROW_W-1:0]  height_reg;
  int                col_pos;
  int                row_pos;
  console_result_t   expected_results [$];

  // zero acts as one, anything above the store size acts as the store size
  function automatic int clamp_size(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic console_result_t console_step(logic op, logic [CHAR_W-1:0] ch,
                                                   logic [COL_W-1:0] rc,
                                                   logic [ROW_W-1:0] rr);
    int w;
    int h;
    console_result_t res;
    w = clamp_size(int'(width_reg), STRIDE);
    h = clamp_size(int'(height_reg), MAX_ROWS_DEF);
    res = '0;
    // pull a cursor left outside a shrunken screen back onto it
    if (col_pos >= w) col_pos = w - 1;
    if (row_pos >= h) row_pos = h - 1;
    if (op == OP_PUT) begin
      if (ch == NEWLINE_CODE) begin
        col_pos = 0;
        row_pos++;
      end else begin
        screen[row_pos * STRIDE + col_pos] = ch;
        col_pos++;
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos++;
        end
      end
      if (row_pos >= h) begin
        // move whole rows, cells beyond the width included
        for (int i = 0; i < (h - 1) * STRIDE; i++) screen[i] = screen[i + STRIDE];
        for (int i = (h - 1) * STRIDE; i < h * STRIDE; i++) screen[i] = '0;
        col_pos = 0;
        row_pos = h - 1;
        res.scrolled = 1'b1;
      end
    end else if (int'(rc) < w && int'(rr) < h) begin
      res.cell_value = screen[int'(rr) * STRIDE + int'(rc)];
    end
    res.cursor_col = col_pos[COL_W-1:0];
    res.cursor_row = row_pos[ROW_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : track
    console_result_t got;
    console_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      foreach (screen[i]) screen[i] = '0;
      width_reg  = COLS_RESET;
      height_reg = ROWS_RESET;
      col_pos    = 0;
      row_pos    = 0;
      expected_results.delete();
      fails   <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_COLS) width_reg = cfg_data[COL_W-1:0];
        else height_reg = cfg_data[ROW_W-1:0];
      end
      // retire results before predicting, so a new item never meets its own slot
      if (out_tvalid && out_tready) begin
        got = out_tdata[20:0];
        if (expected_results.size() == 0) begin
          $error("result item %h with nothing expected", out_tdata);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.cell_value !== want.cell_value) begin
            $error("cell_value expected %0d got %0d", want.cell_value, got.cell_value);
            errs++;
          end
          if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col expected %0d got %0d", want.cursor_col, got.cursor_col);
            errs++;
          end
          if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row expected %0d got %0d", want.cursor_row, got.cursor_row);
            errs++;
          end
          if (got.scrolled !== want.scrolled) begin
            $error("scrolled expected %0d got %0d", want.scrolled, got.scrolled);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(console_step(in_tuser, in_tdata[7:0], in_tdata[14:8],
                                                in_tdata[19:15]));
      end
      fails   <= fails + errs;
      pending <= expected_results.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import tcb_pkg::*;

  // worst case: every item scrolls at its phase height (25 rows, or 4 rows) plus
  // full stalls; the limit leaves room above that worst case
  localparam int CYCLE_LIMIT = 4_000_000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [23:0]      in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [23:0]      out_tdata;
  int               fails;
  int               pending;
  int               cycles = 0;
  bit               calm = 1'b0;

  text_console_buffer i_dut (.*);

  console_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // receiver: drop tready in short bursts until the calm tail
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic int span(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, rr, rc, ch};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // hold until every result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item(input int nl_pct, input int w, input int h);
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  rc;
    logic [ROW_W-1:0]  rr;
    op = ($urandom_range(0, 99) < 35) ? OP_READ : OP_PUT;
    ch = CHAR_W'($urandom_range(0, 255));
    if (op == OP_PUT && $urandom_range(0, 99) < nl_pct) ch = NEWLINE_CODE;
    // mostly cells on screen, now and then anywhere the fields reach
    if ($urandom_range(0, 9) == 0) begin
      rc = COL_W'($urandom_range(0, 127));
      rr = ROW_W'($urandom_range(0, 31));
    end else begin
      rc = COL_W'($urandom_range(0, w - 1));
      rr = ROW_W'($urandom_range(0, h - 1));
    end
    send_item(op, ch, rc, rr);
  endtask

  initial begin
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    int               count;
    int               nl_pct;
    bit               wide;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_COLS;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_PUT;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default 80x25 screen: byte extremes, newline, reads on and off screen
    send_item(OP_READ, 8'h00, 7'd0, 5'd0);
    send_item(OP_PUT, 8'h41, 7'd0, 5'd0);
    send_item(OP_PUT, 8'hFF, 7'd0, 5'd0);
    send_item(OP_PUT, 8'h00, 7'd0, 5'd0);
    send_item(OP_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    send_item(OP_PUT, 8'h7E, 7'd0, 5'd0);
    send_item(OP_PUT, 8'h51, 7'd0, 5'd0);
    send_item(OP_READ, 8'hFF, 7'd0, 5'd0);
    send_item(OP_READ, 8'h00, 7'd1, 5'd0);
    send_item(OP_READ, 8'h00, 7'd1, 5'd1);
    send_item(OP_READ, 8'h00, 7'd79, 5'd24);
    send_item(OP_READ, 8'h00, 7'h7F, 5'h1F);
    send_item(OP_READ, 8'h00, 7'd80, 5'd0);
    send_item(OP_READ, 8'h00, 7'd0, 5'd25);

    // shrink under the cursor, then the wrap scrolls a row with cells past the width
    drain();
    set_geometry(7'd1, 7'd2);
    send_item(OP_PUT, 8'h5A, 7'd0, 5'd0);

    // oversized registers act as the full screen; the moved cells show up in row 0
    drain();
    set_geometry(7'h7F, 7'h7F);
    send_item(OP_READ, 8'h00, 7'd1, 5'd0);
    send_item(OP_READ, 8'h00, 7'd0, 5'd0);

    // zero registers act as a single cell
    drain();
    set_geometry(7'd0, 7'd0);
    send_item(OP_PUT, 8'h33, 7'd0, 5'd0);
    send_item(OP_READ, 8'h00, 7'd0, 5'd0);
    send_item(OP_READ, 8'h00, 7'd1, 5'd0);

    for (int p = 0; p < 8; p++) begin
      wide = (p == 2 || p == 5);
      calm = (p == 7);
      case ($urandom_range(0, 5))
        0: cols = 7'd0;
        1: cols = 7'd1;
        2: cols = CFG_W'($urandom_range(2, 8));
        3: cols = CFG_W'($urandom_range(9, 79));
        4: cols = 7'd80;
        default: cols = 7'h7F;
      endcase
      // tall screens scroll slowly: keep them few, heavy on newlines to reach the bottom
      if (wide) begin
        rows   = (p == 2) ? 7'd25 : 7'h7F;
        count  = 90;
        nl_pct = 70;
      end else begin
        rows   = CFG_W'($urandom_range(0, 4));
        count  = 280;
        nl_pct = 12;
      end
      drain();
      set_geometry(cols, rows);
      repeat (count) begin
        random_item(nl_pct, span(int'(cols), MAX_COLS_DEF),
                    span(int'(rows[ROW_W-1:0]), MAX_ROWS_DEF));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== text_console_buffer.f =====
design/tcb_pkg.sv
design/tcb_ram.sv
design/tcb_ctrl.sv
design/tcb_datapath.sv
design/text_console_buffer.sv
sim/console_checker.sv
sim/testbench.sv
